/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never hold
`define ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("assertion failed");

// cond implies prop in the same cycle
`define ASSERT_IMPLY(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

// cond implies prop in the next cycle
`define ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

`endif

/* rtl/ggrn_pkg.sv */
// Package: widths, register codes, stencil and pipeline types of the grid walker
package ggrn_pkg;

	localparam int unsigned MAX_CELLS_DEF = 4096;

	localparam int CELL_W  = 12;
	localparam int DIM_W   = 13;
	localparam int THR_W   = 10;
	localparam int PICK_W  = 16;
	localparam int IDX_W   = 14;
	localparam int WIDE_W  = 15;
	localparam int DIFF_W  = 14;
	localparam int SQ_W    = 27;
	localparam int DIST_W  = 28;
	localparam int NBR     = 8;
	localparam int RES_W   = 3;
	localparam int CNT_W   = 4;
	localparam int RES_STEPS = PICK_W / 2;
	localparam int DIV_STEPS = CELL_W;

	localparam int IN_W    = 40;
	localparam int OUT_W   = 16;
	localparam int OUSER_W = 3;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [1:0] REG_COLS = 2'd0;
	localparam logic [1:0] REG_ROWS = 2'd1;
	localparam logic [1:0] REG_DEST = 2'd2;
	localparam logic [1:0] REG_THR  = 2'd3;

	localparam logic [DIM_W-1:0]  COLS_RST = 13'd64;
	localparam logic [DIM_W-1:0]  ROWS_RST = 13'd64;
	localparam logic [CELL_W-1:0] DEST_RST = 12'd4095;
	localparam logic [THR_W-1:0]  THR_RST  = 10'd500;

	typedef enum logic [1:0] {OFS_ZERO, OFS_MINUS, OFS_PLUS} ofs_t;

	// stencil: W, NW, SW, E, NE, SE, N, S
	localparam ofs_t NBR_DR [NBR] = '{OFS_ZERO, OFS_MINUS, OFS_PLUS, OFS_ZERO,
		OFS_MINUS, OFS_PLUS, OFS_MINUS, OFS_PLUS};
	localparam ofs_t NBR_DC [NBR] = '{OFS_MINUS, OFS_MINUS, OFS_MINUS, OFS_PLUS,
		OFS_PLUS, OFS_PLUS, OFS_ZERO, OFS_ZERO};

	typedef struct packed {
		logic                      vld;
		logic                      func;
		logic                      blk;
		logic [CELL_W-1:0]         cur;
		logic [THR_W-1:0]          rchoice;
		logic [PICK_W-1:0]         rpick;
		logic [DIM_W-1:0]          crem;
		logic [DIM_W-1:0]          drem;
		logic [CELL_W-1:0]         cq;
		logic [CELL_W-1:0]         dq;
		logic [NBR-1:0][RES_W-1:0] res;
	} dv_t;

	typedef struct packed {
		logic                       vld;
		logic                       func;
		logic [CELL_W-1:0]          cur;
		logic [THR_W-1:0]           rchoice;
		logic [NBR-1:0][RES_W-1:0]  res;
		logic [NBR-1:0]             in_grid;
		logic [NBR-1:0][IDX_W-1:0]  idx;
		logic [NBR-1:0][DIFF_W-1:0] ddr;
		logic [NBR-1:0][DIFF_W-1:0] ddc;
	} nb_t;

	typedef struct packed {
		logic                     vld;
		logic                     func;
		logic [CELL_W-1:0]        cur;
		logic [THR_W-1:0]         rchoice;
		logic [NBR-1:0]           free;
		logic [NBR-1:0]           hit;
		logic [NBR-1:0][IDX_W-1:0] idx;
		logic [NBR-1:0][SQ_W-1:0] sqr;
		logic [NBR-1:0][SQ_W-1:0] sqc;
		logic [RES_W-1:0]         k;
	} sel_t;

	typedef struct packed {
		logic              vld;
		logic              plan;
		logic [CELL_W-1:0] cur;
		logic              greedy;
		logic              none;
		logic              any_hit;
		logic [IDX_W-1:0]  hit_idx;
		logic [IDX_W-1:0]  rnd_idx;
	} ctl_t;

	typedef struct packed {
		logic              ok;
		logic [DIST_W-1:0] sqd;
		logic [IDX_W-1:0]  idx;
	} cand_t;

	// earlier candidate wins ties
	function automatic cand_t best_of(cand_t a, cand_t b);
		cand_t r;
		r = a;
		if (b.ok && (!a.ok || b.sqd < a.sqd)) begin
			r = b;
		end
		return r;
	endfunction

endpackage

/* rtl/ggrn_ram.sv */
// Generic single-write, single-read RAM with registered read data
module ggrn_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/grid_greedy_random_neighbor_step.sv */
// Top level: grid walker step pipeline with obstacle map and APB registers
// Pipeline: a plan item passes 20 register stages on its way to m_tvalid.
// Throughput: one item per cycle unless a held output with m_tready low stalls the
// pipeline; a 12-stage divider (row/column of the cell and of the destination) feeds
// map reads, squared distances and a min tree. Reset: registers take their reset values
// and the map is cleared by a pass over all MAX_CELLS addresses, during which s_tready is low.
`include "assert_macros.svh"

module grid_greedy_random_neighbor_step #(
	parameter int unsigned MAX_CELLS = ggrn_pkg::MAX_CELLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cell_req[11:0], blocked[12], rand_choice[22:13], rand_pick[38:23], zero pad
	input  logic [ggrn_pkg::IN_W-1:0]     s_tdata,
	// func
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// next_cell[11:0], zero pad
	output logic [ggrn_pkg::OUT_W-1:0]    m_tdata,
	// reached_dest[0], moved_greedy[1], stuck[2]
	output logic [ggrn_pkg::OUSER_W-1:0]  m_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ggrn_pkg::ADDR_W-1:0]   paddr,
	input  logic [ggrn_pkg::DATA_W-1:0]   pwdata,
	output logic [ggrn_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int AW = $clog2(MAX_CELLS);
	localparam int DIV = ggrn_pkg::DIV_STEPS;
	localparam int NBR = ggrn_pkg::NBR;

	logic [ggrn_pkg::DIM_W-1:0]  cols_q;
	logic [ggrn_pkg::DIM_W-1:0]  rows_q;
	logic [ggrn_pkg::CELL_W-1:0] dest_q;
	logic [ggrn_pkg::THR_W-1:0]  thr_q;

	logic          adv;
	logic [AW-1:0] clr_q;
	logic          clr_done_q;

	ggrn_pkg::dv_t  dv_s [DIV+1];
	ggrn_pkg::dv_t  dv_nx [DIV];
	ggrn_pkg::nb_t  nb_s14, nb_nx;
	ggrn_pkg::sel_t sel_s15, sel_nx;
	ggrn_pkg::ctl_t pk_ctl_s16, pk_ctl_nx;
	ggrn_pkg::cand_t pk_s16 [NBR];
	ggrn_pkg::cand_t pk_nx [NBR];
	ggrn_pkg::ctl_t t1_ctl_s17, t2_ctl_s18, t3_ctl_s19;
	ggrn_pkg::cand_t t1_s17 [NBR/2];
	ggrn_pkg::cand_t t2_s18 [NBR/4];
	ggrn_pkg::cand_t t3_s19;

	logic                         out_vld_q;
	logic [ggrn_pkg::CELL_W-1:0]  out_cell_q;
	logic                         out_reach_q, out_greedy_q, out_stuck_q;

	logic [NBR-1:0] map_bit;
	logic [AW-1:0]  raddr [NBR];
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic           ram_wdata;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= ggrn_pkg::COLS_RST;
			rows_q <= ggrn_pkg::ROWS_RST;
			dest_q <= ggrn_pkg::DEST_RST;
			thr_q  <= ggrn_pkg::THR_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				ggrn_pkg::REG_COLS: cols_q <= pwdata[ggrn_pkg::DIM_W-1:0];
				ggrn_pkg::REG_ROWS: rows_q <= pwdata[ggrn_pkg::DIM_W-1:0];
				ggrn_pkg::REG_DEST: dest_q <= pwdata[ggrn_pkg::CELL_W-1:0];
				ggrn_pkg::REG_THR:  thr_q  <= pwdata[ggrn_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ggrn_pkg::REG_COLS: prdata = ggrn_pkg::DATA_W'(cols_q);
			ggrn_pkg::REG_ROWS: prdata = ggrn_pkg::DATA_W'(rows_q);
			ggrn_pkg::REG_DEST: prdata = ggrn_pkg::DATA_W'(dest_q);
			ggrn_pkg::REG_THR:  prdata = ggrn_pkg::DATA_W'(thr_q);
			default:            prdata = '0;
		endcase
	end

	// map clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(MAX_CELLS - 1)) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	assign adv      = !out_vld_q || m_tready;
	assign s_tready = adv && clr_done_q;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= '0;
		end else if (adv) begin
			dv_s[0].vld     <= s_tvalid && s_tready;
			dv_s[0].func    <= s_tuser[0];
			dv_s[0].cur     <= s_tdata[11:0];
			dv_s[0].blk     <= s_tdata[12];
			dv_s[0].rchoice <= s_tdata[22:13];
			dv_s[0].rpick   <= s_tdata[38:23];
			dv_s[0].crem    <= '0;
			dv_s[0].drem    <= '0;
			dv_s[0].cq      <= '0;
			dv_s[0].dq      <= '0;
			dv_s[0].res     <= '0;
		end
	end

	// restoring divider by grid_cols, one quotient bit per stage; rand_pick
	// residues mod 1..8, two bits per stage
	for (genvar j = 0; j < DIV; j++) begin : g_div
		logic [ggrn_pkg::DIM_W:0] cs, ds;
		logic [ggrn_pkg::DIM_W:0] cdiv;
		logic                     cge, dge;
		logic [4:0]               t;
		logic [1:0]               pb;

		always_comb begin
			dv_nx[j] = dv_s[j];
			cdiv = {1'b0, cols_q};
			cs   = {dv_s[j].crem, dv_s[j].cur[ggrn_pkg::CELL_W-1-j]};
			ds   = {dv_s[j].drem, dest_q[ggrn_pkg::CELL_W-1-j]};
			cge  = cs >= cdiv;
			dge  = ds >= cdiv;
			dv_nx[j].crem = cge ? ggrn_pkg::DIM_W'(cs - cdiv) : cs[ggrn_pkg::DIM_W-1:0];
			dv_nx[j].drem = dge ? ggrn_pkg::DIM_W'(ds - cdiv) : ds[ggrn_pkg::DIM_W-1:0];
			dv_nx[j].cq = {dv_s[j].cq[ggrn_pkg::CELL_W-2:0], cge};
			dv_nx[j].dq = {dv_s[j].dq[ggrn_pkg::CELL_W-2:0], dge};
			t  = '0;
			pb = '0;
			if (j < ggrn_pkg::RES_STEPS) begin
				pb = dv_s[j].rpick[ggrn_pkg::PICK_W-1-2*(j % ggrn_pkg::RES_STEPS) -: 2];
				for (int n = 1; n <= NBR; n++) begin
					t = {dv_s[j].res[n-1], pb};
					if (t >= 5'(2*n)) begin
						t = t - 5'(2*n);
					end
					if (t >= 5'(n)) begin
						t = t - 5'(n);
					end
					dv_nx[j].res[n-1] = t[ggrn_pkg::RES_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j+1] <= '0;
			end else if (adv) begin
				dv_s[j+1] <= dv_nx[j];
			end
		end
	end

	// neighbour indices, bounds and distance terms
	always_comb begin
		logic signed [ggrn_pkg::DIFF_W-1:0] nr, nc;
		logic signed [ggrn_pkg::WIDE_W-1:0] base, idxw;
		logic                               rok, cok;
		nb_nx         = '0;
		nb_nx.vld     = dv_s[DIV].vld;
		nb_nx.func    = dv_s[DIV].func;
		nb_nx.cur     = dv_s[DIV].cur;
		nb_nx.rchoice = dv_s[DIV].rchoice;
		nb_nx.res     = dv_s[DIV].res;
		for (int i = 0; i < NBR; i++) begin
			nr   = $signed({2'b00, dv_s[DIV].cq});
			base = $signed({3'b000, dv_s[DIV].cur});
			case (ggrn_pkg::NBR_DR[i])
				ggrn_pkg::OFS_MINUS: begin
					nr   = nr - 14'sd1;
					base = base - $signed({2'b00, cols_q});
				end
				ggrn_pkg::OFS_PLUS: begin
					nr   = nr + 14'sd1;
					base = base + $signed({2'b00, cols_q});
				end
				default: ;
			endcase
			nc   = $signed({1'b0, dv_s[DIV].crem});
			idxw = base;
			case (ggrn_pkg::NBR_DC[i])
				ggrn_pkg::OFS_MINUS: begin
					nc   = nc - 14'sd1;
					idxw = base - 15'sd1;
				end
				ggrn_pkg::OFS_PLUS: begin
					nc   = nc + 14'sd1;
					idxw = base + 15'sd1;
				end
				default: ;
			endcase
			rok = !nr[ggrn_pkg::DIFF_W-1] && (nr[ggrn_pkg::DIM_W-1:0] < rows_q);
			cok = !nc[ggrn_pkg::DIFF_W-1] && (nc[ggrn_pkg::DIM_W-1:0] < cols_q);
			nb_nx.in_grid[i] = rok && cok
				&& (32'(idxw[ggrn_pkg::IDX_W-1:0]) < MAX_CELLS);
			nb_nx.idx[i] = idxw[ggrn_pkg::IDX_W-1:0];
			nb_nx.ddr[i] = ggrn_pkg::DIFF_W'(nr - $signed({2'b00, dv_s[DIV].dq}));
			nb_nx.ddc[i] = ggrn_pkg::DIFF_W'(nc - $signed({1'b0, dv_s[DIV].drem}));
			raddr[i] = AW'(idxw[ggrn_pkg::IDX_W-1:0]);
		end
	end

	// map: one copy per stencil position, writes go to all
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 1'b0;
		if (!clr_done_q) begin
			ram_we = 1'b1;
		end else if (adv && dv_s[DIV].vld && !dv_s[DIV].func
			&& 32'(dv_s[DIV].cur) < MAX_CELLS) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(dv_s[DIV].cur);
			ram_wdata = dv_s[DIV].blk;
		end
	end

	for (genvar i = 0; i < NBR; i++) begin : g_map
		ggrn_ram #(
			.WIDTH (1),
			.DEPTH (MAX_CELLS)
		) u_map (
			.clk   (clk),
			.we    (ram_we),
			.waddr (ram_waddr),
			.wdata (ram_wdata),
			.re    (adv),
			.raddr (raddr[i]),
			.rdata (map_bit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_s14 <= '0;
		end else if (adv) begin
			nb_s14 <= nb_nx;
		end
	end

	// free mask, destination hits, squares, random residue
	always_comb begin
		logic [ggrn_pkg::CNT_W-1:0]      nfree;
		logic signed [2*ggrn_pkg::DIFF_W-1:0] pr, pc;
		sel_nx         = '0;
		sel_nx.vld     = nb_s14.vld;
		sel_nx.func    = nb_s14.func;
		sel_nx.cur     = nb_s14.cur;
		sel_nx.rchoice = nb_s14.rchoice;
		sel_nx.idx     = nb_s14.idx;
		sel_nx.free    = nb_s14.in_grid & ~map_bit;
		for (int i = 0; i < NBR; i++) begin
			sel_nx.hit[i] = sel_nx.free[i] && (nb_s14.idx[i] == {2'b00, dest_q});
			pr = $signed(nb_s14.ddr[i]) * $signed(nb_s14.ddr[i]);
			pc = $signed(nb_s14.ddc[i]) * $signed(nb_s14.ddc[i]);
			sel_nx.sqr[i] = pr[ggrn_pkg::SQ_W-1:0];
			sel_nx.sqc[i] = pc[ggrn_pkg::SQ_W-1:0];
		end
		nfree = ggrn_pkg::CNT_W'($countones(sel_nx.free));
		if (nfree != '0) begin
			sel_nx.k = nb_s14.res[ggrn_pkg::RES_W'(nfree - 1'b1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_s15 <= '0;
		end else if (adv) begin
			sel_s15 <= sel_nx;
		end
	end

	// distances, random and destination picks
	always_comb begin
		logic [ggrn_pkg::CNT_W-1:0] cnt;
		pk_ctl_nx        = '0;
		pk_ctl_nx.vld    = sel_s15.vld;
		pk_ctl_nx.plan   = sel_s15.func;
		pk_ctl_nx.cur    = sel_s15.cur;
		pk_ctl_nx.greedy = sel_s15.rchoice < thr_q;
		pk_ctl_nx.none   = sel_s15.free == '0;
		pk_ctl_nx.any_hit = |sel_s15.hit;
		cnt = '0;
		for (int i = 0; i < NBR; i++) begin
			if (sel_s15.free[i] && cnt == {1'b0, sel_s15.k}) begin
				pk_ctl_nx.rnd_idx = sel_s15.idx[i];
			end
			cnt = cnt + ggrn_pkg::CNT_W'(sel_s15.free[i]);
		end
		for (int i = NBR - 1; i >= 0; i--) begin
			if (sel_s15.hit[i]) begin
				pk_ctl_nx.hit_idx = sel_s15.idx[i];
			end
		end
		for (int i = 0; i < NBR; i++) begin
			pk_nx[i].ok  = sel_s15.free[i];
			pk_nx[i].sqd = {1'b0, sel_s15.sqr[i]} + {1'b0, sel_s15.sqc[i]};
			pk_nx[i].idx = sel_s15.idx[i];
		end
	end

	// registered min tree
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_ctl_s16 <= '0;
			t1_ctl_s17 <= '0;
			t2_ctl_s18 <= '0;
			t3_ctl_s19 <= '0;
			t3_s19     <= '0;
			for (int i = 0; i < NBR; i++) begin
				pk_s16[i] <= '0;
			end
			for (int i = 0; i < NBR/2; i++) begin
				t1_s17[i] <= '0;
			end
			for (int i = 0; i < NBR/4; i++) begin
				t2_s18[i] <= '0;
			end
		end else if (adv) begin
			pk_ctl_s16 <= pk_ctl_nx;
			t1_ctl_s17 <= pk_ctl_s16;
			t2_ctl_s18 <= t1_ctl_s17;
			t3_ctl_s19 <= t2_ctl_s18;
			for (int i = 0; i < NBR; i++) begin
				pk_s16[i] <= pk_nx[i];
			end
			for (int i = 0; i < NBR/2; i++) begin
				t1_s17[i] <= ggrn_pkg::best_of(pk_s16[2*i], pk_s16[2*i+1]);
			end
			for (int i = 0; i < NBR/4; i++) begin
				t2_s18[i] <= ggrn_pkg::best_of(t1_s17[2*i], t1_s17[2*i+1]);
			end
			t3_s19 <= ggrn_pkg::best_of(t2_s18[0], t2_s18[1]);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q    <= 1'b0;
			out_cell_q   <= '0;
			out_reach_q  <= 1'b0;
			out_greedy_q <= 1'b0;
			out_stuck_q  <= 1'b0;
		end else if (adv) begin
			out_vld_q    <= t3_ctl_s19.vld && t3_ctl_s19.plan;
			out_reach_q  <= 1'b0;
			out_greedy_q <= 1'b0;
			out_stuck_q  <= 1'b0;
			if (t3_ctl_s19.none) begin
				out_cell_q  <= t3_ctl_s19.cur;
				out_stuck_q <= 1'b1;
			end else if (t3_ctl_s19.any_hit) begin
				out_cell_q  <= t3_ctl_s19.hit_idx[ggrn_pkg::CELL_W-1:0];
				out_reach_q <= 1'b1;
			end else if (t3_ctl_s19.greedy) begin
				out_cell_q   <= t3_s19.idx[ggrn_pkg::CELL_W-1:0];
				out_greedy_q <= 1'b1;
			end else begin
				out_cell_q <= t3_ctl_s19.rnd_idx[ggrn_pkg::CELL_W-1:0];
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = ggrn_pkg::OUT_W'(out_cell_q);
	assign m_tuser  = {out_stuck_q, out_greedy_q, out_reach_q};

	`ASSERT_NEVER(a_no_accept_in_clear, s_tready && !clr_done_q)
	`ASSERT_NEVER(a_flags_exclusive, m_tvalid && $countones(m_tuser) > 1)
	`ASSERT_NEXT(a_nb_holds_on_stall, nb_s14.vld && !adv, $stable(nb_s14))

endmodule
